// ===== rtl/core/sos_pkg.sv =====
// Shared constants, shape tables and payload types of the sprite shape slicer.
package sos_pkg;

  localparam int IN_W        = 5;
  localparam int COORD_W     = 4;
  localparam int TILE_W      = 8;
  localparam int TOTAL_W     = 9;
  localparam int SEG_LIMIT   = 64;
  localparam int SEG_CNT_W   = 7;
  localparam int NUM_SHAPES  = 12;
  localparam int SHAPE_IDX_W = 4;
  localparam int PROBE_ROWS  = 8;
  localparam int PROBE_IDX_W = 3;
  localparam int RUN_W       = 4;

  // Sprite sizes that use a hand-made layout instead of the greedy cover.
  localparam int FIX_A_W = 13;
  localparam int FIX_A_H = 8;
  localparam int FIX_B_W = 6;
  localparam int FIX_B_H = 3;
  localparam int FIX_A_CNT = 5;
  localparam int FIX_B_CNT = 4;

  typedef struct packed {
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } shape_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } place_t;

  typedef struct packed {
    place_t             pos;
    logic [TILE_W-1:0]  first_tile;
  } seg_t;

  // Candidate shapes in order of preference.
  localparam shape_t SHAPES [NUM_SHAPES] = '{
    '{4'd8, 4'd8}, '{4'd8, 4'd4}, '{4'd4, 4'd8}, '{4'd4, 4'd4},
    '{4'd4, 4'd2}, '{4'd4, 4'd1}, '{4'd2, 4'd4}, '{4'd2, 4'd2},
    '{4'd2, 4'd1}, '{4'd1, 4'd4}, '{4'd1, 4'd2}, '{4'd1, 4'd1}
  };

  localparam place_t LAYOUT_A [FIX_A_CNT] = '{
    '{4'd0,  4'd0, 4'd8, 4'd4}, '{4'd0,  4'd4, 4'd8, 4'd4},
    '{4'd8,  4'd0, 4'd4, 4'd8}, '{4'd12, 4'd0, 4'd1, 4'd4},
    '{4'd12, 4'd4, 4'd1, 4'd4}
  };

  localparam place_t LAYOUT_B [FIX_B_CNT] = '{
    '{4'd0, 4'd0, 4'd4, 4'd2}, '{4'd0, 4'd2, 4'd4, 4'd1},
    '{4'd4, 4'd0, 4'd2, 4'd2}, '{4'd4, 4'd2, 4'd2, 4'd1}
  };

endpackage

// ===== rtl/core/sos_chan_if.sv =====
// Valid/ready channel interfaces for the request and segment streams.
interface sos_in_if;
  logic                     valid;
  logic                     ready;
  logic [sos_pkg::IN_W-1:0] sprite_width;
  logic [sos_pkg::IN_W-1:0] sprite_height;

  modport source (output valid, sprite_width, sprite_height, input ready);
  modport sink   (input valid, sprite_width, sprite_height, output ready);
endinterface

interface sos_out_if;
  logic                        valid;
  logic                        ready;
  logic [sos_pkg::COORD_W-1:0] seg_x;
  logic [sos_pkg::COORD_W-1:0] seg_y;
  logic [sos_pkg::COORD_W-1:0] seg_w;
  logic [sos_pkg::COORD_W-1:0] seg_h;
  logic [sos_pkg::TILE_W-1:0]  first_tile;
  logic [sos_pkg::TOTAL_W-1:0] total_tiles;
  logic                        last;

  modport source (output valid, seg_x, seg_y, seg_w, seg_h, first_tile, total_tiles, last,
                  input ready);
  modport sink   (input valid, seg_x, seg_y, seg_w, seg_h, first_tile, total_tiles, last,
                  output ready);
endinterface

// ===== rtl/core/sprite_oam_shape_slicer.sv =====
// Sprite shape slicer: cuts a sprite of whole tiles into hardware sprite segments.
//
// A request transaction on in_chan carries the sprite width and height in tiles.
// Sizes above MAX_SIDE are clamped to MAX_SIDE; a zero side gives no segments.
// The 13x8 and 6x3 sizes use fixed layouts of five and four segments. Any other
// size is covered greedily: cells are scanned row-major, and at each free cell
// the first of twelve shapes that fits inside the sprite and over free cells is
// placed. One out_chan transaction is sent per segment; the final one has last
// set and carries the total tile count. At most 64 segments are sent per sprite.
// Requests are taken one at a time, only while the block is idle. The used-cell
// map lives in a single-port-read memory of MAX_SIDE rows; per-row valid bits
// are cleared in the accept cycle, so there is no clearing pass after reset.
// Greedy scan: each row is read, then loaded, then scanned cell by cell; at each
// free cell up to 8 rows are probed, then a shape is picked, its rows are marked
// and the segment is placed. Fixed layouts place one segment per cycle unless
// the receiver stalls. Each segment is held back in a pending register so that
// last can be set on it; a stalled receiver stalls the scan.
// Reset clears the control state; the block then waits idle for a request.
module sprite_oam_shape_slicer #(
  parameter int MAX_SIDE = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  sos_in_if.sink           in_chan,
  sos_out_if.source        out_chan
);

  localparam int AW = $clog2(MAX_SIDE);
  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int XW = SW + 1;
  localparam int CW = (SW > sos_pkg::IN_W) ? SW : sos_pkg::IN_W;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RDROW = 10'b0000000010,
    S_LOAD  = 10'b0000000100,
    S_SCAN  = 10'b0000001000,
    S_PROBE = 10'b0000010000,
    S_PICK  = 10'b0000100000,
    S_MARK  = 10'b0001000000,
    S_PLACE = 10'b0010000000,
    S_FIX   = 10'b0100000000,
    S_FINAL = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [SW-1:0] x_r, x_nxt, y_r, y_nxt, w_r, w_nxt, h_r, h_nxt;
  logic [MAX_SIDE-1:0] cur_row_r, cur_row_nxt;
  logic [MAX_SIDE-1:0] row_vld_r, row_vld_nxt;

  logic [sos_pkg::PROBE_IDX_W:0]   iss_r, iss_nxt;
  logic [sos_pkg::PROBE_IDX_W:0]   nrows_r, nrows_nxt;
  logic                            rdv_r, rdv_nxt;
  logic [sos_pkg::PROBE_IDX_W-1:0] ridx_r, ridx_nxt;
  logic [sos_pkg::RUN_W-1:0]       run_r   [sos_pkg::PROBE_ROWS];
  logic [sos_pkg::RUN_W-1:0]       run_nxt [sos_pkg::PROBE_ROWS];
  logic [MAX_SIDE-1:0]             rows_r   [sos_pkg::PROBE_ROWS];
  logic [MAX_SIDE-1:0]             rows_nxt [sos_pkg::PROBE_ROWS];

  logic [sos_pkg::COORD_W-1:0]     sel_w_r, sel_w_nxt, sel_h_r, sel_h_nxt;
  logic [sos_pkg::PROBE_IDX_W-1:0] mk_r, mk_nxt;

  logic [sos_pkg::TOTAL_W-1:0]   tile_r, tile_nxt;
  logic [sos_pkg::SEG_CNT_W-1:0] nseg_r, nseg_nxt;
  logic                          fix_b_r, fix_b_nxt;
  logic [2:0]                    fi_r, fi_nxt;

  logic          pend_v_r, pend_v_nxt;
  sos_pkg::seg_t pend_r, pend_nxt;

  logic                        out_valid_r, out_valid_nxt;
  sos_pkg::seg_t               out_seg_r, out_seg_nxt;
  logic [sos_pkg::TOTAL_W-1:0] out_total_r, out_total_nxt;
  logic                        out_last_r, out_last_nxt;

  // Used-cell memory, one row of cells per entry.
  logic [MAX_SIDE-1:0] used_mem [MAX_SIDE];
  logic [MAX_SIDE-1:0] mem_q_r;
  logic                q_vld_r;
  logic                rd_en, wr_en;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [MAX_SIDE-1:0] wr_data;
  logic [MAX_SIDE-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      used_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= used_mem[rd_addr];
      q_vld_r <= row_vld_r[rd_addr];
    end
  end

  // A row never written during this request reads as all free.
  assign rd_data = q_vld_r ? mem_q_r : '0;

  // Free run length starting at the current column in the returned row.
  logic [MAX_SIDE-1:0]       shifted;
  logic [sos_pkg::RUN_W-1:0] run_raw, run_val;
  logic [SW-1:0]             lim;
  logic                      run_stop;

  always_comb begin
    shifted  = rd_data >> x_r;
    run_raw  = '0;
    run_stop = 1'b0;
    for (int k = 0; k < sos_pkg::PROBE_ROWS; k++) begin
      if (!run_stop && !shifted[k]) begin
        run_raw = sos_pkg::RUN_W'(k + 1);
      end else begin
        run_stop = 1'b1;
      end
    end
    lim     = w_r - x_r;
    run_val = (SW'(run_raw) > lim) ? sos_pkg::RUN_W'(lim) : run_raw;
  end

  // First shape whose width fits the free run of every row it covers.
  logic [sos_pkg::SHAPE_IDX_W-1:0] pick_idx;
  logic                            fit;

  always_comb begin
    pick_idx = sos_pkg::SHAPE_IDX_W'(sos_pkg::NUM_SHAPES - 1);
    for (int i = sos_pkg::NUM_SHAPES - 1; i >= 0; i--) begin
      fit = 1'b1;
      for (int dy = 0; dy < sos_pkg::PROBE_ROWS; dy++) begin
        if ((sos_pkg::COORD_W'(dy) < sos_pkg::SHAPES[i].h) &&
            (run_r[dy] < sos_pkg::SHAPES[i].w)) begin
          fit = 1'b0;
        end
      end
      if (fit) begin
        pick_idx = sos_pkg::SHAPE_IDX_W'(i);
      end
    end
  end

  // Cell mask of the selected shape on its rows.
  logic [MAX_SIDE-1:0] mk_mask;
  logic [XW-1:0]       mask_end;

  always_comb begin
    mask_end = {1'b0, x_r} + XW'(sel_w_r);
    for (int j = 0; j < MAX_SIDE; j++) begin
      mk_mask[j] = (XW'(j) >= {1'b0, x_r}) && (XW'(j) < mask_end);
    end
  end

  logic [sos_pkg::COORD_W-1:0] step;
  logic [XW-1:0]               adv_x;
  logic                        row_end, last_row;
  logic                        slot_free;
  logic [SW-1:0]               rows_left;
  logic [CW-1:0]               w_in, h_in, ws_c, hs_c;
  sos_pkg::place_t             fix_ent;
  logic                        fix_end;
  logic [sos_pkg::TOTAL_W-1:0] sel_area, fix_area;

  always_comb begin
    step      = (state_r == S_PLACE) ? sel_w_r : sos_pkg::COORD_W'(1);
    adv_x     = {1'b0, x_r} + XW'(step);
    row_end   = adv_x >= {1'b0, w_r};
    last_row  = (y_r + SW'(1)) == h_r;
    slot_free = !out_valid_r || out_chan.ready;
    rows_left = h_r - y_r;

    w_in = CW'(in_chan.sprite_width);
    h_in = CW'(in_chan.sprite_height);
    ws_c = (w_in > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : w_in;
    hs_c = (h_in > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : h_in;

    fix_ent = fix_b_r ? sos_pkg::LAYOUT_B[fi_r[1:0]] : sos_pkg::LAYOUT_A[fi_r];
    fix_end = fix_b_r ? (fi_r == 3'(sos_pkg::FIX_B_CNT - 1))
                      : (fi_r == 3'(sos_pkg::FIX_A_CNT - 1));
    fix_area = {5'd0, fix_ent.w} * {5'd0, fix_ent.h};
    sel_area = {5'd0, sel_w_r} * {5'd0, sel_h_r};
  end

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    cur_row_nxt   = cur_row_r;
    row_vld_nxt   = row_vld_r;
    iss_nxt       = iss_r;
    nrows_nxt     = nrows_r;
    rdv_nxt       = 1'b0;
    ridx_nxt      = ridx_r;
    run_nxt       = run_r;
    rows_nxt      = rows_r;
    sel_w_nxt     = sel_w_r;
    sel_h_nxt     = sel_h_r;
    mk_nxt        = mk_r;
    tile_nxt      = tile_r;
    nseg_nxt      = nseg_r;
    fix_b_nxt     = fix_b_r;
    fi_nxt        = fi_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_seg_nxt   = out_seg_r;
    out_total_nxt = out_total_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    rd_addr       = y_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = AW'(y_r + SW'(mk_r));
    wr_data       = rows_r[mk_r] | mk_mask;

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          w_nxt      = SW'(ws_c);
          h_nxt      = SW'(hs_c);
          x_nxt      = '0;
          y_nxt      = '0;
          tile_nxt   = '0;
          nseg_nxt   = '0;
          fi_nxt     = '0;
          pend_v_nxt = 1'b0;
          if (ws_c == '0 || hs_c == '0) begin
            state_nxt = S_IDLE;
          end else if (ws_c == CW'(sos_pkg::FIX_A_W) && hs_c == CW'(sos_pkg::FIX_A_H)) begin
            fix_b_nxt = 1'b0;
            state_nxt = S_FIX;
          end else if (ws_c == CW'(sos_pkg::FIX_B_W) && hs_c == CW'(sos_pkg::FIX_B_H)) begin
            fix_b_nxt = 1'b1;
            state_nxt = S_FIX;
          end else begin
            row_vld_nxt = '0;
            state_nxt   = S_RDROW;
          end
        end
      end

      S_RDROW: begin
        rd_en     = 1'b1;
        state_nxt = S_LOAD;
      end

      S_LOAD: begin
        cur_row_nxt = rd_data;
        state_nxt   = S_SCAN;
      end

      S_SCAN: begin
        if (cur_row_r[x_r[AW-1:0]]) begin
          // Cell already covered: move on.
          if (!row_end) begin
            x_nxt = SW'(adv_x);
          end else if (last_row) begin
            state_nxt = S_FINAL;
          end else begin
            x_nxt     = '0;
            y_nxt     = y_r + SW'(1);
            state_nxt = S_RDROW;
          end
        end else begin
          iss_nxt   = '0;
          nrows_nxt = (rows_left > SW'(sos_pkg::PROBE_ROWS)) ?
                      (sos_pkg::PROBE_IDX_W + 1)'(sos_pkg::PROBE_ROWS) :
                      (sos_pkg::PROBE_IDX_W + 1)'(rows_left);
          for (int k = 0; k < sos_pkg::PROBE_ROWS; k++) begin
            run_nxt[k] = '0;
          end
          state_nxt = S_PROBE;
        end
      end

      S_PROBE: begin
        // One row read issued per cycle; each return is folded in on the next cycle.
        if (iss_r != nrows_r) begin
          rd_en    = 1'b1;
          rd_addr  = AW'(y_r + SW'(iss_r));
          iss_nxt  = iss_r + 1'b1;
          rdv_nxt  = 1'b1;
          ridx_nxt = iss_r[sos_pkg::PROBE_IDX_W-1:0];
        end
        if (rdv_r) begin
          run_nxt[ridx_r]  = run_val;
          rows_nxt[ridx_r] = rd_data;
          if (iss_r == nrows_r) begin
            state_nxt = S_PICK;
          end
        end
      end

      S_PICK: begin
        sel_w_nxt = sos_pkg::SHAPES[pick_idx].w;
        sel_h_nxt = sos_pkg::SHAPES[pick_idx].h;
        mk_nxt    = '0;
        state_nxt = S_MARK;
      end

      S_MARK: begin
        wr_en = 1'b1;
        row_vld_nxt[wr_addr] = 1'b1;
        cur_row_nxt = cur_row_r | mk_mask;
        if ({1'b0, mk_r} == sel_h_r - 1'b1) begin
          state_nxt = S_PLACE;
        end else begin
          mk_nxt = mk_r + 1'b1;
        end
      end

      S_PLACE: begin
        if (!pend_v_r || slot_free) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_seg_nxt   = pend_r;
            out_total_nxt = '0;
            out_last_nxt  = 1'b0;
          end
          pend_v_nxt          = 1'b1;
          pend_nxt.pos.x      = x_r[sos_pkg::COORD_W-1:0];
          pend_nxt.pos.y      = y_r[sos_pkg::COORD_W-1:0];
          pend_nxt.pos.w      = sel_w_r;
          pend_nxt.pos.h      = sel_h_r;
          pend_nxt.first_tile = tile_r[sos_pkg::TILE_W-1:0];
          tile_nxt            = tile_r + sel_area;
          nseg_nxt            = nseg_r + 1'b1;
          if (nseg_r == sos_pkg::SEG_CNT_W'(sos_pkg::SEG_LIMIT - 1)) begin
            state_nxt = S_FINAL;
          end else if (!row_end) begin
            x_nxt     = SW'(adv_x);
            state_nxt = S_SCAN;
          end else if (last_row) begin
            state_nxt = S_FINAL;
          end else begin
            x_nxt     = '0;
            y_nxt     = y_r + SW'(1);
            state_nxt = S_RDROW;
          end
        end
      end

      S_FIX: begin
        if (!pend_v_r || slot_free) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_seg_nxt   = pend_r;
            out_total_nxt = '0;
            out_last_nxt  = 1'b0;
          end
          pend_v_nxt          = 1'b1;
          pend_nxt.pos        = fix_ent;
          pend_nxt.first_tile = tile_r[sos_pkg::TILE_W-1:0];
          tile_nxt            = tile_r + fix_area;
          fi_nxt              = fi_r + 1'b1;
          if (fix_end) begin
            state_nxt = S_FINAL;
          end
        end
      end

      S_FINAL: begin
        // The held segment is the last one; it carries the running total.
        if (slot_free) begin
          out_valid_nxt = pend_v_r;
          out_seg_nxt   = pend_r;
          out_total_nxt = tile_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      rdv_r       <= 1'b0;
      row_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
      rdv_r       <= rdv_nxt;
      row_vld_r   <= row_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    w_r         <= w_nxt;
    h_r         <= h_nxt;
    cur_row_r   <= cur_row_nxt;
    iss_r       <= iss_nxt;
    nrows_r     <= nrows_nxt;
    ridx_r      <= ridx_nxt;
    run_r       <= run_nxt;
    rows_r      <= rows_nxt;
    sel_w_r     <= sel_w_nxt;
    sel_h_r     <= sel_h_nxt;
    mk_r        <= mk_nxt;
    tile_r      <= tile_nxt;
    nseg_r      <= nseg_nxt;
    fix_b_r     <= fix_b_nxt;
    fi_r        <= fi_nxt;
    pend_r      <= pend_nxt;
    out_seg_r   <= out_seg_nxt;
    out_total_r <= out_total_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.seg_x       = out_seg_r.pos.x;
  assign out_chan.seg_y       = out_seg_r.pos.y;
  assign out_chan.seg_w       = out_seg_r.pos.w;
  assign out_chan.seg_h       = out_seg_r.pos.h;
  assign out_chan.first_tile  = out_seg_r.first_tile;
  assign out_chan.total_tiles = out_total_r;
  assign out_chan.last        = out_last_r;

endmodule
